### hdl/ratm_pkg.sv
// Package for the recurring alarm table matcher.
// Holds table sizing, operation, mode and status codes, and the slot record
// and controller/datapath interface types. Depends on nothing.
package ratm_pkg;

    localparam int SLOTS  = 16;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_W = 48;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    localparam logic [15:0] ID_FIRST  = 16'd1;
    localparam logic [15:0] ID_MAX    = 16'hFFFF;
    localparam logic [7:0]  NO_MINUTE = 8'd255;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ADD    = 2'd1,
        OP_TOGGLE = 2'd2,
        OP_DELETE = 2'd3
    } op_t;

    localparam logic [2:0] MODE_ONCE     = 3'd0;
    localparam logic [2:0] MODE_DAILY    = 3'd1;
    localparam logic [2:0] MODE_WEEKDAYS = 3'd2;
    localparam logic [2:0] MODE_WEEKENDS = 3'd3;
    localparam logic [2:0] MODE_CUSTOM   = 3'd4;
    localparam logic [2:0] MODE_DATE     = 3'd5;

    localparam logic [2:0] WD_SUNDAY   = 3'd0;
    localparam logic [2:0] WD_MONDAY   = 3'd1;
    localparam logic [2:0] WD_FRIDAY   = 3'd5;
    localparam logic [2:0] WD_SATURDAY = 3'd6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [15:0] id;
        logic [10:0] hm;
        logic [2:0]  mode;
        logic [6:0]  days;
        logic [8:0]  date;
        logic [1:0]  tone;
    } slot_t;

    typedef struct packed {
        logic             load;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_stat_t;

endpackage

### hdl/ratm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package use.
module ratm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic                                         rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hdl/ratm_ctrl.sv
// Controller for the alarm matcher: accepts a word, sweeps the slot table,
// then commits the result. Depends on ratm_pkg.
module ratm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ratm_pkg::dp_stat_t  stat,
    output ratm_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_COMMIT = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    logic [ratm_pkg::IDX_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ratm_pkg::LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign cmd.load    = in_valid && (state_reg == S_IDLE);
    assign cmd.rd_en   = (state_reg == S_SCAN);
    assign cmd.rd_addr = cnt_reg;
    assign cmd.commit  = (state_reg == S_COMMIT) && !stat.out_busy;

endmodule

### hdl/ratm_dp.sv
// Datapath for the alarm matcher: input word, slot table (RAM plus valid and
// enable flags), sweep evaluation, commit and output register.
// Depends on ratm_pkg and ratm_ram.
module ratm_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  ratm_pkg::ctrl_cmd_t cmd,
    output ratm_pkg::dp_stat_t  stat,
    input  logic [1:0]          op,
    input  logic [4:0]          clock_hour,
    input  logic [5:0]          clock_minute,
    input  logic [2:0]          weekday,
    input  logic [3:0]          month_number,
    input  logic [4:0]          day_number,
    input  logic [2:0]          repeat_mode,
    input  logic [6:0]          day_mask,
    input  logic [1:0]          tone_kind,
    input  logic [15:0]         alarm_id,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                fired,
    output logic [15:0]         fired_id,
    output logic [1:0]          fired_tone,
    output logic [15:0]         new_id,
    output logic [1:0]          status
);

    localparam int N = ratm_pkg::SLOTS;
    localparam int W = ratm_pkg::IDX_W;

    // latched input word
    ratm_pkg::op_t op_reg;
    logic [4:0]    hr_reg;
    logic [5:0]    mn_reg;
    logic [2:0]    wd_reg;
    logic [3:0]    mo_reg;
    logic [4:0]    dy_reg;
    logic [2:0]    mode_reg;
    logic [6:0]    mask_reg;
    logic [1:0]    tone_reg;
    logic [15:0]   id_reg;
    logic          skip_reg;

    logic [7:0]    last_min_reg;
    logic [15:0]   next_id_reg;
    logic [N-1:0]  valid_reg;
    logic [N-1:0]  enabled_reg;

    logic          eval_reg;
    logic [W-1:0]  eval_idx_reg;
    logic          found_reg;
    logic [W-1:0]  best_idx_reg;
    logic [15:0]   best_id_reg;
    logic [1:0]    best_tone_reg;
    logic [2:0]    best_mode_reg;

    logic          out_valid_reg;
    logic          fired_reg;
    logic [15:0]   fired_id_reg;
    logic [1:0]    fired_tone_reg;
    logic [15:0]   new_id_reg;
    logic [1:0]    status_reg;

    logic [ratm_pkg::SLOT_W-1:0] rd_data;
    logic [ratm_pkg::SLOT_W-1:0] wr_data;
    logic                        wr_en;
    ratm_pkg::slot_t             rec;
    ratm_pkg::slot_t             new_rec;

    logic       ent_valid;
    logic       ent_en;
    logic       mode_ok;
    logic       tick_match;
    logic       take;
    logic [7:0] days_ext;
    logic [7:0] minute_ext;
    logic       is_tick, is_add, is_toggle, is_delete;
    logic       disarm;

    assign rec        = ratm_pkg::slot_t'(rd_data);
    assign ent_valid  = valid_reg[eval_idx_reg];
    assign ent_en     = enabled_reg[eval_idx_reg];
    assign days_ext   = {1'b0, rec.days};
    assign minute_ext = {2'b00, clock_minute};

    assign is_tick   = (op_reg == ratm_pkg::OP_TICK);
    assign is_add    = (op_reg == ratm_pkg::OP_ADD);
    assign is_toggle = (op_reg == ratm_pkg::OP_TOGGLE);
    assign is_delete = (op_reg == ratm_pkg::OP_DELETE);
    assign disarm    = (best_mode_reg == ratm_pkg::MODE_ONCE)
                    || (best_mode_reg == ratm_pkg::MODE_DATE);

    always_comb
    begin
        unique case (rec.mode)
            ratm_pkg::MODE_ONCE,
            ratm_pkg::MODE_DAILY:    mode_ok = 1'b1;
            ratm_pkg::MODE_WEEKDAYS: mode_ok = (wd_reg >= ratm_pkg::WD_MONDAY)
                                            && (wd_reg <= ratm_pkg::WD_FRIDAY);
            ratm_pkg::MODE_WEEKENDS: mode_ok = (wd_reg == ratm_pkg::WD_SUNDAY)
                                            || (wd_reg == ratm_pkg::WD_SATURDAY);
            ratm_pkg::MODE_CUSTOM:   mode_ok = days_ext[wd_reg];
            ratm_pkg::MODE_DATE:     mode_ok = (rec.date == {mo_reg, dy_reg});
            default:                 mode_ok = 1'b0;
        endcase
    end

    assign tick_match = !skip_reg && ent_valid && ent_en
                     && (rec.hm == {hr_reg, mn_reg}) && mode_ok;

    // lowest id wins on a tick; strict compare keeps the lowest index on ties
    always_comb
    begin
        unique case (op_reg)
            ratm_pkg::OP_TICK:   take = tick_match
                                     && (!found_reg || (rec.id < best_id_reg));
            ratm_pkg::OP_ADD:    take = !ent_valid && !found_reg;
            ratm_pkg::OP_TOGGLE,
            ratm_pkg::OP_DELETE: take = ent_valid && (rec.id == id_reg) && !found_reg;
            default:             take = 1'b0;
        endcase
    end

    assign new_rec.id   = next_id_reg;
    assign new_rec.hm   = {hr_reg, mn_reg};
    assign new_rec.mode = mode_reg;
    assign new_rec.days = mask_reg;
    assign new_rec.date = {mo_reg, dy_reg};
    assign new_rec.tone = tone_reg;
    assign wr_data      = new_rec;
    assign wr_en        = cmd.commit && is_add && found_reg;

    ratm_ram #(
        .WIDTH (ratm_pkg::SLOT_W),
        .DEPTH (N)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (best_idx_reg),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= ratm_pkg::op_t'(op);
            hr_reg   <= clock_hour;
            mn_reg   <= clock_minute;
            wd_reg   <= weekday;
            mo_reg   <= month_number;
            dy_reg   <= day_number;
            mode_reg <= repeat_mode;
            mask_reg <= day_mask;
            tone_reg <= tone_kind;
            id_reg   <= alarm_id;
            skip_reg <= (minute_ext == last_min_reg);
        end
        eval_idx_reg <= cmd.rd_addr;
        if (eval_reg && take)
        begin
            best_idx_reg  <= eval_idx_reg;
            best_id_reg   <= rec.id;
            best_tone_reg <= rec.tone;
            best_mode_reg <= rec.mode;
        end
        if (cmd.commit)
        begin
            fired_reg      <= is_tick && found_reg;
            fired_id_reg   <= (is_tick && found_reg) ? best_id_reg : '0;
            fired_tone_reg <= (is_tick && found_reg) ? best_tone_reg : '0;
            new_id_reg     <= (is_add && found_reg) ? next_id_reg : '0;
            if (is_add && !found_reg)
            begin
                status_reg <= ratm_pkg::ST_FULL;
            end
            else if ((is_toggle || is_delete) && !found_reg)
            begin
                status_reg <= ratm_pkg::ST_NOT_FOUND;
            end
            else
            begin
                status_reg <= ratm_pkg::ST_OK;
            end
        end
    end

    // enable flags are only read for valid slots
    always_ff @(posedge clk)
    begin
        if (cmd.commit && found_reg)
        begin
            if (is_add)
            begin
                enabled_reg[best_idx_reg] <= 1'b1;
            end
            else if (is_toggle)
            begin
                enabled_reg[best_idx_reg] <= !enabled_reg[best_idx_reg];
            end
            else if (is_tick && disarm)
            begin
                enabled_reg[best_idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_min_reg  <= ratm_pkg::NO_MINUTE;
            next_id_reg   <= ratm_pkg::ID_FIRST;
            valid_reg     <= '0;
            eval_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            eval_reg <= cmd.rd_en;
            if (cmd.load && (ratm_pkg::op_t'(op) == ratm_pkg::OP_TICK)
                && (minute_ext != last_min_reg))
            begin
                last_min_reg <= minute_ext;
            end
            if (cmd.load)
            begin
                found_reg <= 1'b0;
            end
            else if (eval_reg && take)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.commit && found_reg && is_add)
            begin
                valid_reg[best_idx_reg] <= 1'b1;
                next_id_reg <= (next_id_reg == ratm_pkg::ID_MAX) ? ratm_pkg::ID_FIRST
                                                                 : next_id_reg + 16'd1;
            end
            else if (cmd.commit && found_reg && is_delete)
            begin
                valid_reg[best_idx_reg] <= 1'b0;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_busy = out_valid_reg && !out_ready;

    assign out_valid  = out_valid_reg;
    assign fired      = fired_reg;
    assign fired_id   = fired_id_reg;
    assign fired_tone = fired_tone_reg;
    assign new_id     = new_id_reg;
    assign status     = status_reg;

endmodule

### hdl/recurring_alarm_table_matcher.sv
// Recurring alarm table matcher, top level: controller plus datapath.
// Every word sweeps all SLOTS table entries through the slot RAM read port,
// one entry a cycle; the result word is then registered in the commit state, and
// a new word may be taken while the previous result still waits at the output.
// Commit waits while the output register still holds an unaccepted result.
// Reset (rst_n, async, active low) empties the table, sets the next id to 1.
module recurring_alarm_table_matcher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [4:0]  clock_hour,
    input  logic [5:0]  clock_minute,
    input  logic [2:0]  weekday,
    input  logic [3:0]  month_number,
    input  logic [4:0]  day_number,
    input  logic [2:0]  repeat_mode,
    input  logic [6:0]  day_mask,
    input  logic [1:0]  tone_kind,
    input  logic [15:0] alarm_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        fired,
    output logic [15:0] fired_id,
    output logic [1:0]  fired_tone,
    output logic [15:0] new_id,
    output logic [1:0]  status
);

    ratm_pkg::ctrl_cmd_t cmd;
    ratm_pkg::dp_stat_t  stat;

    ratm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ratm_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .op           (op),
        .clock_hour   (clock_hour),
        .clock_minute (clock_minute),
        .weekday      (weekday),
        .month_number (month_number),
        .day_number   (day_number),
        .repeat_mode  (repeat_mode),
        .day_mask     (day_mask),
        .tone_kind    (tone_kind),
        .alarm_id     (alarm_id),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .fired        (fired),
        .fired_id     (fired_id),
        .fired_tone   (fired_tone),
        .new_id       (new_id),
        .status       (status)
    );

endmodule

### hdl/ratm_checker.sv
// Port-level checker for the alarm matcher, bound to the top level.
// Depends on ratm_pkg for status codes.
module ratm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        fired,
    input logic [15:0] fired_id,
    input logic [1:0]  fired_tone,
    input logic [15:0] new_id,
    input logic [1:0]  status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fired) && $stable(fired_id)
            && $stable(fired_tone) && $stable(new_id) && $stable(status))
        else $error("result word changed while stalled");

    a_fire_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fired |-> fired_id != 16'd0 && new_id == 16'd0
            && status == ratm_pkg::ST_OK)
        else $error("fired word carries add or error fields");

    a_quiet_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !fired |-> fired_id == 16'd0 && fired_tone == 2'd0)
        else $error("fire fields set without a fire");

    a_add_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && new_id != 16'd0 |-> status == ratm_pkg::ST_OK && !fired)
        else $error("new id given with error or fire");

endmodule

bind recurring_alarm_table_matcher ratm_checker u_ratm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .fired      (fired),
    .fired_id   (fired_id),
    .fired_tone (fired_tone),
    .new_id     (new_id),
    .status     (status)
);

### tb/sv/recurring_alarm_table_matcher_checker.sv
// Checker for the recurring alarm table matcher: watches both channels, keeps its
// own copy of the alarm table, predicts every result word and compares it.
// Depends on ratm_pkg for codes, sizes and the slot record.
module recurring_alarm_table_matcher_checker
    import ratm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  op,
    input  logic [4:0]  clock_hour,
    input  logic [5:0]  clock_minute,
    input  logic [2:0]  weekday,
    input  logic [3:0]  month_number,
    input  logic [4:0]  day_number,
    input  logic [2:0]  repeat_mode,
    input  logic [6:0]  day_mask,
    input  logic [1:0]  tone_kind,
    input  logic [15:0] alarm_id,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        fired,
    input  logic [15:0] fired_id,
    input  logic [1:0]  fired_tone,
    input  logic [15:0] new_id,
    input  logic [1:0]  status,
    output int          fail_count,
    output int          pending,
    output int          words_checked,
    output int          alarms_fired,
    output int          adds_refused,
    output int          ids_missing
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        fired;
        logic [15:0] fired_id;
        logic [1:0]  fired_tone;
        logic [15:0] new_id;
        logic [1:0]  status;
    } alarm_word_t;

    slot_t       alarm_slots [SLOTS];
    bit          slot_live   [SLOTS];
    bit          slot_armed  [SLOTS];
    logic [15:0] next_id     = ID_FIRST;
    logic [7:0]  last_minute = NO_MINUTE;
    alarm_word_t expected_words [$];

    function automatic bit slot_hits(int i, logic [10:0] hm, logic [2:0] wd,
                                     logic [8:0] md);
        if (!slot_live[i] || !slot_armed[i] || alarm_slots[i].hm != hm)
            return 1'b0;
        case (alarm_slots[i].mode)
            MODE_ONCE, MODE_DAILY: return 1'b1;
            MODE_WEEKDAYS:         return wd >= WD_MONDAY && wd <= WD_FRIDAY;
            MODE_WEEKENDS:         return wd == WD_SUNDAY || wd == WD_SATURDAY;
            MODE_CUSTOM:           return wd <= WD_SATURDAY && alarm_slots[i].days[wd];
            MODE_DATE:             return alarm_slots[i].date == md;
            default:               return 1'b0;
        endcase
    endfunction

    function automatic alarm_word_t predict_alarm_word(
        op_t o, logic [4:0] hr, logic [5:0] mn, logic [2:0] wd, logic [3:0] mo,
        logic [4:0] dy, logic [2:0] mode, logic [6:0] mask, logic [1:0] tone,
        logic [15:0] id);
        alarm_word_t w;
        int hit;
        logic [10:0] hm;
        logic [8:0] md;
        w = '0;
        hit = -1;
        hm = {hr, mn};
        md = {mo, dy};
        case (o)
            OP_TICK:
            begin
                if ({2'b00, mn} != last_minute)
                begin
                    last_minute = {2'b00, mn};
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_hits(i, hm, wd, md) &&
                            (hit < 0 || alarm_slots[i].id < alarm_slots[hit].id))
                            hit = i;
                    if (hit >= 0)
                    begin
                        w.fired = 1'b1;
                        w.fired_id = alarm_slots[hit].id;
                        w.fired_tone = alarm_slots[hit].tone;
                        if (alarm_slots[hit].mode == MODE_ONCE ||
                            alarm_slots[hit].mode == MODE_DATE)
                            slot_armed[hit] = 1'b0;
                    end
                end
            end
            OP_ADD:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (!slot_live[i] && hit < 0)
                        hit = i;
                if (hit < 0)
                    w.status = ST_FULL;
                else
                begin
                    alarm_slots[hit] = '{id: next_id, hm: hm, mode: mode, days: mask,
                                         date: md, tone: tone};
                    slot_armed[hit] = 1'b1;
                    slot_live[hit] = 1'b1;
                    w.new_id = next_id;
                    next_id = (next_id == ID_MAX) ? ID_FIRST : next_id + 16'd1;
                end
            end
            default:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot_live[i] && alarm_slots[i].id == id && hit < 0)
                        hit = i;
                if (hit < 0)
                    w.status = ST_NOT_FOUND;
                else if (o == OP_TOGGLE)
                    slot_armed[hit] = !slot_armed[hit];
                else
                    slot_live[hit] = 1'b0;
            end
        endcase
        return w;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        alarm_word_t want;
        alarm_word_t predicted;
        if (!rst_n)
        begin
            foreach (slot_live[i])
            begin
                slot_live[i] = 1'b0;
                slot_armed[i] = 1'b0;
                alarm_slots[i] = '0;
            end
            next_id = ID_FIRST;
            last_minute = NO_MINUTE;
            expected_words.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with no prediction waiting");
                    fail_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("fired", want.fired, fired);
                    check_field("fired_id", want.fired_id, fired_id);
                    check_field("fired_tone", want.fired_tone, fired_tone);
                    check_field("new_id", want.new_id, new_id);
                    check_field("status", want.status, status);
                    words_checked++;
                    alarms_fired += want.fired;
                    adds_refused += (want.status == ST_FULL);
                    ids_missing += (want.status == ST_NOT_FOUND);
                end
            end
            if (in_valid && in_ready)
            begin
                predicted = predict_alarm_word(op_t'(op), clock_hour,
                    clock_minute, weekday, month_number, day_number, repeat_mode,
                    day_mask, tone_kind, alarm_id);
                expected_words = {expected_words, predicted};
            end
        end
        pending = expected_words.size();
    end

endmodule

### tb/sv/recurring_alarm_table_matcher_tb.sv
// Testbench top for the recurring alarm table matcher: clock, reset, stimulus,
// idling on both channels and the verdict. Needs ratm_pkg, the block and
// recurring_alarm_table_matcher_checker.
module recurring_alarm_table_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ratm_pkg::*;

    localparam logic [2:0] WD_NONE        = 3'd7;
    localparam logic [2:0] MODE_SPARE_LO  = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI  = 3'd7;
    localparam int         RANDOM_WORDS   = 1100;
    localparam int         HOLD_AT        = 950;
    localparam int         HOLD_CYCLES    = 300;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [4:0]  clock_hour;
    logic [5:0]  clock_minute;
    logic [2:0]  weekday;
    logic [3:0]  month_number;
    logic [4:0]  day_number;
    logic [2:0]  repeat_mode;
    logic [6:0]  day_mask;
    logic [1:0]  tone_kind;
    logic [15:0] alarm_id;
    logic        out_valid;
    logic        out_ready;
    logic        fired;
    logic [15:0] fired_id;
    logic [1:0]  fired_tone;
    logic [15:0] new_id;
    logic [1:0]  status;

    int fail_count;
    int pending;
    int words_checked;
    int alarms_fired;
    int adds_refused;
    int ids_missing;

    int send_idle = 0;
    int recv_idle = 0;
    bit hold_off  = 1'b0;
    int words_sent = 0;
    int adds_issued = 0;

    logic [4:0] hour_pool [4] = '{5'd0, 5'd8, 5'd17, 5'd23};
    logic [5:0] min_pool  [4] = '{6'd0, 6'd15, 6'd45, 6'd59};

    recurring_alarm_table_matcher u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .clock_hour(clock_hour), .clock_minute(clock_minute),
        .weekday(weekday), .month_number(month_number), .day_number(day_number),
        .repeat_mode(repeat_mode), .day_mask(day_mask), .tone_kind(tone_kind),
        .alarm_id(alarm_id),
        .out_valid(out_valid), .out_ready(out_ready),
        .fired(fired), .fired_id(fired_id), .fired_tone(fired_tone),
        .new_id(new_id), .status(status)
    );

    recurring_alarm_table_matcher_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .clock_hour(clock_hour), .clock_minute(clock_minute),
        .weekday(weekday), .month_number(month_number), .day_number(day_number),
        .repeat_mode(repeat_mode), .day_mask(day_mask), .tone_kind(tone_kind),
        .alarm_id(alarm_id),
        .out_valid(out_valid), .out_ready(out_ready),
        .fired(fired), .fired_id(fired_id), .fired_tone(fired_tone),
        .new_id(new_id), .status(status),
        .fail_count(fail_count), .pending(pending), .words_checked(words_checked),
        .alarms_fired(alarms_fired), .adds_refused(adds_refused),
        .ids_missing(ids_missing)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // returns at the rising edge that took the word
    task automatic offer_word(op_t o, logic [4:0] hr, logic [5:0] mn, logic [2:0] wd,
                              logic [3:0] mo, logic [4:0] dy, logic [2:0] mode,
                              logic [6:0] mask, logic [1:0] tone, logic [15:0] id);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        op = o;
        clock_hour = hr;
        clock_minute = mn;
        weekday = wd;
        month_number = mo;
        day_number = dy;
        repeat_mode = mode;
        day_mask = mask;
        tone_kind = tone;
        alarm_id = id;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    task automatic issue_tick(logic [4:0] hr, logic [5:0] mn, logic [2:0] wd,
                              logic [3:0] mo, logic [4:0] dy);
        offer_word(OP_TICK, hr, mn, wd, mo, dy, 3'($urandom), 7'($urandom),
                   2'($urandom), 16'($urandom));
    endtask

    task automatic issue_add(logic [4:0] hr, logic [5:0] mn, logic [2:0] mode,
                             logic [6:0] mask, logic [3:0] mo, logic [4:0] dy,
                             logic [1:0] tone);
        offer_word(OP_ADD, hr, mn, 3'($urandom), mo, dy, mode, mask, tone,
                   16'($urandom));
        adds_issued++;
    endtask

    task automatic issue_edit(op_t o, logic [15:0] id);
        offer_word(o, 5'($urandom), 6'($urandom), 3'($urandom), 4'($urandom),
                   5'($urandom), 3'($urandom), 7'($urandom), 2'($urandom), id);
    endtask

    task automatic issue_random_word();
        int pick;
        logic [4:0] hr;
        logic [5:0] mn;
        logic [3:0] mo;
        logic [4:0] dy;
        logic [2:0] mode;
        logic [15:0] id;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0)
        begin
            hr = 5'($urandom);
            mn = 6'($urandom);
        end
        else
        begin
            hr = hour_pool[$urandom_range(0, 3)];
            mn = min_pool[$urandom_range(0, 3)];
        end
        if ($urandom_range(0, 4) == 0)
        begin
            mo = 4'($urandom);
            dy = 5'($urandom);
        end
        else
        begin
            mo = $urandom_range(0, 1) ? 4'd12 : 4'd1;
            dy = $urandom_range(0, 1) ? 5'd31 : 5'd1;
        end
        mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI))
                                           : 3'($urandom_range(MODE_ONCE, MODE_DATE));
        if ($urandom_range(0, 9) == 0 || adds_issued == 0)
            id = 16'($urandom);
        else
            id = 16'($urandom_range((adds_issued > 24) ? adds_issued - 24 : 1,
                                    adds_issued + 1));
        if (pick < 45)
            issue_tick(hr, mn, 3'($urandom), mo, dy);
        else if (pick < 70)
            issue_add(hr, mn, mode, 7'($urandom), mo, dy, 2'($urandom));
        else if (pick < 82)
            issue_edit(OP_TOGGLE, id);
        else
            issue_edit(OP_DELETE, id);
    endtask

    // receiver: random stalls, plus the long hold-off
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = !hold_off && ($urandom_range(0, 99) >= recv_idle);
        end
    end

    initial
    begin
        wait (words_sent >= HOLD_AT);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_TICK;
        clock_hour = '0;
        clock_minute = '0;
        weekday = '0;
        month_number = '0;
        day_number = '0;
        repeat_mode = '0;
        day_mask = '0;
        tone_kind = '0;
        alarm_id = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle = 13;
        recv_idle = 88;

        // directed: empty table, every mode, same minute, weekday seven, edits
        issue_tick(5'd0, 6'd0, WD_SUNDAY, 4'd1, 5'd1);
        issue_edit(OP_TOGGLE, 16'd0);
        issue_edit(OP_DELETE, 16'hFFFF);
        issue_add(5'd23, 6'd59, MODE_ONCE, 7'h00, 4'd0, 5'd0, 2'd3);
        issue_add(5'd0, 6'd0, MODE_DAILY, 7'h7F, 4'd0, 5'd0, 2'd0);
        issue_add(5'd7, 6'd30, MODE_WEEKDAYS, 7'h00, 4'd0, 5'd0, 2'd1);
        issue_add(5'd7, 6'd30, MODE_WEEKENDS, 7'h00, 4'd0, 5'd0, 2'd2);
        issue_add(5'd7, 6'd30, MODE_CUSTOM, 7'h55, 4'd0, 5'd0, 2'd3);
        issue_add(5'd31, 6'd63, MODE_DATE, 7'h00, 4'd15, 5'd31, 2'd2);
        issue_add(5'd0, 6'd0, MODE_SPARE_HI, 7'h7F, 4'd0, 5'd0, 2'd1);
        issue_add(5'd7, 6'd30, MODE_SPARE_LO, 7'h7F, 4'd0, 5'd0, 2'd0);
        issue_tick(5'd0, 6'd0, WD_SUNDAY, 4'd1, 5'd1);
        issue_tick(5'd23, 6'd59, WD_MONDAY, 4'd1, 5'd1);
        issue_tick(5'd0, 6'd0, WD_NONE, 4'd1, 5'd1);
        issue_tick(5'd23, 6'd59, WD_MONDAY, 4'd1, 5'd1);
        issue_tick(5'd7, 6'd30, WD_NONE, 4'd1, 5'd1);
        issue_tick(5'd31, 6'd63, WD_FRIDAY, 4'd15, 5'd31);
        issue_tick(5'd7, 6'd30, WD_SATURDAY, 4'd1, 5'd1);
        issue_tick(5'd31, 6'd63, WD_FRIDAY, 4'd15, 5'd31);
        issue_tick(5'd7, 6'd30, WD_MONDAY, 4'd12, 5'd31);
        issue_edit(OP_TOGGLE, 16'd2);
        issue_tick(5'd0, 6'd0, WD_MONDAY, 4'd1, 5'd1);
        issue_edit(OP_TOGGLE, 16'd2);
        issue_edit(OP_DELETE, 16'd3);
        issue_edit(OP_DELETE, 16'd3);
        issue_add(5'd8, 6'd15, MODE_DAILY, 7'h2A, 4'd1, 5'd1, 2'd1);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS / 3)
            begin
                send_idle = 88;
                recv_idle = 13;
            end
            else if (n == 2 * RANDOM_WORDS / 3)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            issue_random_word();
        end
        @(negedge clk);
        in_valid = 1'b0;

        wait (pending == 0);
        repeat (3 * SLOTS) @(posedge clk);

        $display("Covered %0d words: %0d alarms fired, %0d adds refused on a full table,",
                 words_checked, alarms_fired, adds_refused);
        $display("%0d edits of unknown ids, with stalls on both sides and a long hold-off.",
                 ids_missing);
        if (pending != 0)
            $error("%0d result words never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
hdl/ratm_pkg.sv
hdl/ratm_ram.sv
hdl/ratm_ctrl.sv
hdl/ratm_dp.sv
hdl/recurring_alarm_table_matcher.sv
hdl/ratm_checker.sv
tb/sv/recurring_alarm_table_matcher_checker.sv
tb/sv/recurring_alarm_table_matcher_tb.sv
